/* rtl/core/event_flag_group_with_waiters_defines.svh */
// ----------------------------------------------------------------------------
// Event flag group assertion macros
// Shared concurrent assertion forms used by the event flag group RTL.
// ----------------------------------------------------------------------------
`ifndef EVENT_FLAG_GROUP_WITH_WAITERS_DEFINES_SVH
`define EVENT_FLAG_GROUP_WITH_WAITERS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EFG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EFG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/efg_pkg.sv */
// ----------------------------------------------------------------------------
// Event flag group package
// Opcodes, status codes, mode bits and the match and consume functions.
// ----------------------------------------------------------------------------
`default_nettype none

package efg_pkg;

  localparam int unsigned FlagW       = 64;
  localparam int unsigned OpW         = 3;
  localparam int unsigned ModeW       = 8;
  localparam int unsigned TagW        = 3;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned WokenW      = 4;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned MaxWaitersDefault = 8;

  // Mode field bits.
  localparam logic [ModeW-1:0] WaitType  = 8'h03;
  localparam logic [ModeW-1:0] ClearBoth = 8'h30;

  typedef enum logic [OpW-1:0] {
    OP_SET     = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_WAIT    = 3'd2,
    OP_TRYWAIT = 3'd3,
    OP_CANCEL  = 3'd4,
    OP_TIMEOUT = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_BUSY      = 3'd2,
    ST_TIMED_OUT = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STICKY  = 1'd0,
    CFG_INITIAL = 1'd1
  } cfg_idx_e;

  // Stored waiter mode: OR mode, clear all, clear pattern.
  typedef struct packed {
    logic clr_pat;
    logic clr_all;
    logic or_mode;
  } wmode_t;

  function automatic logic efg_met(logic [FlagW-1:0] flags, logic [FlagW-1:0] pat,
                                   wmode_t wm);
    logic [FlagW-1:0] hit;
    hit = flags & pat;
    if (wm.or_mode) begin
      return hit != '0;
    end
    return hit == pat;
  endfunction

  function automatic logic [FlagW-1:0] efg_consume(logic [FlagW-1:0] flags,
                                                   logic [FlagW-1:0] pat,
                                                   wmode_t wm,
                                                   logic [FlagW-1:0] sticky);
    logic [FlagW-1:0] nxt;
    nxt = flags;
    if (wm.clr_all) begin
      nxt = '0;
    end else if (wm.clr_pat) begin
      nxt = flags & ~pat;
    end
    return nxt | sticky;
  endfunction

  function automatic logic efg_bad_req(logic [FlagW-1:0] pat, logic [ModeW-1:0] mode);
    return (pat == '0) || ((mode & WaitType) == '0) || ((mode & WaitType) == WaitType)
        || ((mode & ClearBoth) == ClearBoth);
  endfunction

  function automatic wmode_t efg_decode_mode(logic [ModeW-1:0] mode);
    wmode_t wm;
    wm.or_mode = mode[1];
    wm.clr_all = mode[4];
    wm.clr_pat = mode[5];
    return wm;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/efg_req_if.sv */
// ----------------------------------------------------------------------------
// Event flag group request channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
`default_nettype none

interface efg_req_if;
  logic                        valid;
  logic                        ready;
  logic [efg_pkg::OpW-1:0]     opcode;
  logic [efg_pkg::FlagW-1:0]   pattern;
  logic [efg_pkg::ModeW-1:0]   mode;
  logic [efg_pkg::TagW-1:0]    waiter_tag;

  modport source (output valid, opcode, pattern, mode, waiter_tag, input ready);
  modport sink   (input valid, opcode, pattern, mode, waiter_tag, output ready);
endinterface

`default_nettype wire

/* rtl/core/efg_rsp_if.sv */
// ----------------------------------------------------------------------------
// Event flag group result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface efg_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [efg_pkg::StatusW-1:0]   status;
  logic [efg_pkg::TagW-1:0]      tag_out;
  logic [efg_pkg::FlagW-1:0]     result_bits;
  logic [efg_pkg::WokenW-1:0]    woken_count;
  logic                          last;

  modport source (output valid, status, tag_out, result_bits, woken_count, last,
                  input ready);
  modport sink   (input valid, status, tag_out, result_bits, woken_count, last,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/event_flag_group_with_waiters.sv */
// ----------------------------------------------------------------------------
// Event flag group with waiters
// 64-bit event flag word with an ordered table of pending waiters.
// ----------------------------------------------------------------------------
// Usage:
//   req_i takes one operation item (set, clear, wait, trywait, cancel or
//   timeout) when valid and ready are both high. rsp_o delivers zero or more
//   result items per operation; the final one carries last. A wait that
//   queues produces no result at all.
//   The block works on one item at a time. After acceptance, a sequencer
//   walks the waiter table one entry per cycle through a single match and
//   consume unit: clear, wait and the unknown opcodes make one decision,
//   set and cancel visit every queued waiter, and timeout stops at the
//   first queued waiter whose tag matches.
//   Results leave through one output register, so ready returns as soon as
//   the final result is registered. If the receiver stalls, the walk pauses
//   on the next result until the output register frees up.
//   cfg_we_i writes sticky_bits (index 0) or initial_bits (index 1), the
//   latter also loading the flag word; write only while the block is idle.
//   Reset clears the flag word, the sticky bits and the waiter count, and
//   the block is ready in the first cycle after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

`include "event_flag_group_with_waiters_defines.svh"

module event_flag_group_with_waiters #(
  parameter int unsigned MAX_WAITERS = efg_pkg::MaxWaitersDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  efg_req_if.sink                            req_i,
  efg_rsp_if.source                          rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [efg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [efg_pkg::FlagW-1:0]     cfg_data_i
);
  import efg_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_WAITERS + 1);
  localparam int unsigned AddrW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [OpW-1:0]    op_q;
  logic [FlagW-1:0]  pat_q;
  logic [ModeW-1:0]  mode_q;
  logic [TagW-1:0]   tag_q;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [FlagW-1:0]  flag_q, flag_d;
  logic [FlagW-1:0]  sticky_q;

  // Waiter table; only entries below cnt_q hold queued waiters.
  logic [FlagW-1:0]  wpat_q [MAX_WAITERS];
  wmode_t            wmode_q [MAX_WAITERS];
  logic [TagW-1:0]   wid_q [MAX_WAITERS];

  logic              out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [TagW-1:0]   out_tag_q;
  logic [FlagW-1:0]  out_bits_q;
  logic [WokenW-1:0] out_woken_q;
  logic              out_last_q;

  logic              accept;
  logic              out_free;
  logic              in_range;
  logic [AddrW-1:0]  rd_addr;
  logic [FlagW-1:0]  ent_pat;
  wmode_t            ent_mode;
  logic [TagW-1:0]   ent_id;
  wmode_t            req_mode;
  logic [CntW+WokenW-1:0] cnt_ext;

  logic              emit;
  status_e           e_status;
  logic [TagW-1:0]   e_tag;
  logic [FlagW-1:0]  e_bits;
  logic [WokenW-1:0] e_woken;
  logic              e_last;
  logic              drop_en;
  logic              push_en;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign in_range = idx_q < cnt_q;
  assign rd_addr  = idx_q[AddrW-1:0];
  assign ent_pat  = wpat_q[rd_addr];
  assign ent_mode = wmode_q[rd_addr];
  assign ent_id   = wid_q[rd_addr];
  assign req_mode = efg_decode_mode(mode_q);
  assign cnt_ext  = {{WokenW{1'b0}}, cnt_q};

  assign req_i.ready = (state_q == S_IDLE);

  // One table entry or one decision per cycle; a step that emits waits while the output register is full.
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    flag_d   = flag_q;
    emit     = 1'b0;
    e_status = ST_OK;
    e_tag    = '0;
    e_bits   = '0;
    e_woken  = '0;
    e_last   = 1'b0;
    drop_en  = 1'b0;
    push_en  = 1'b0;
    if (state_q == S_SCAN) begin
      unique case (op_q) inside
        OP_SET: begin
          if (in_range) begin
            if (efg_met(flag_q, ent_pat, ent_mode)) begin
              if (out_free) begin
                emit    = 1'b1;
                e_tag   = ent_id;
                e_bits  = flag_q;
                flag_d  = efg_consume(flag_q, ent_pat, ent_mode, sticky_q);
                drop_en = 1'b1;
                cnt_d   = cnt_q - 1'b1;
              end
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end else if (out_free) begin
            emit    = 1'b1;
            e_bits  = flag_q;
            e_last  = 1'b1;
            state_d = S_IDLE;
          end
        end
        OP_CLEAR: begin
          if (out_free) begin
            flag_d  = flag_q & pat_q;
            emit    = 1'b1;
            e_bits  = flag_q & pat_q;
            e_last  = 1'b1;
            state_d = S_IDLE;
          end
        end
        OP_WAIT, OP_TRYWAIT: begin
          if (out_free) begin
            state_d = S_IDLE;
            e_tag   = tag_q;
            e_last  = 1'b1;
            if (efg_bad_req(pat_q, mode_q)) begin
              emit     = 1'b1;
              e_status = ST_INVALID;
            end else if (efg_met(flag_q, pat_q, req_mode)) begin
              emit   = 1'b1;
              e_bits = flag_q;
              flag_d = efg_consume(flag_q, pat_q, req_mode, sticky_q);
            end else if (op_q == OP_TRYWAIT) begin
              emit     = 1'b1;
              e_status = ST_BUSY;
            end else if (cnt_q >= CntW'(MAX_WAITERS)) begin
              emit     = 1'b1;
              e_status = ST_FULL;
            end else begin
              push_en = 1'b1;
              cnt_d   = cnt_q + 1'b1;
            end
          end
        end
        OP_CANCEL: begin
          if (out_free) begin
            emit   = 1'b1;
            e_bits = pat_q;
            if (in_range) begin
              e_status = ST_CANCELLED;
              e_tag    = ent_id;
              idx_d    = idx_q + 1'b1;
            end else begin
              e_woken = cnt_ext[WokenW-1:0];
              e_last  = 1'b1;
              cnt_d   = '0;
              state_d = S_IDLE;
            end
          end
        end
        OP_TIMEOUT: begin
          if (in_range && ent_id != tag_q) begin
            idx_d = idx_q + 1'b1;
          end else if (out_free) begin
            emit     = 1'b1;
            e_tag    = tag_q;
            e_last   = 1'b1;
            state_d  = S_IDLE;
            if (in_range) begin
              e_status = ST_TIMED_OUT;
              drop_en  = 1'b1;
              cnt_d    = cnt_q - 1'b1;
            end else begin
              e_status = ST_INVALID;
            end
          end
        end
        default: begin
          if (out_free) begin
            emit     = 1'b1;
            e_status = ST_INVALID;
            e_tag    = tag_q;
            e_last   = 1'b1;
            state_d  = S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      flag_q      <= '0;
      sticky_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= accept ? '0 : idx_d;
      if (cfg_we_i && cfg_idx_i == CFG_STICKY) begin
        sticky_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_INITIAL) begin
        flag_q <= cfg_data_i;
      end else if (accept && req_i.opcode == OP_SET) begin
        flag_q <= flag_q | req_i.pattern;
      end else begin
        flag_q <= flag_d;
      end
      if (accept) begin
        state_q <= S_SCAN;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.opcode;
      pat_q  <= req_i.pattern;
      mode_q <= req_i.mode;
      tag_q  <= req_i.waiter_tag;
    end
    if (emit) begin
      out_status_q <= e_status;
      out_tag_q    <= e_tag;
      out_bits_q   <= e_bits;
      out_woken_q  <= e_woken;
      out_last_q   <= e_last;
    end
  end

  // Removing an entry shifts every later entry down by one place.
  always_ff @(posedge clk_i) begin
    if (drop_en) begin
      for (int j = 0; j < int'(MAX_WAITERS) - 1; j++) begin
        if (CntW'(j) >= idx_q) begin
          wpat_q[j]  <= wpat_q[j+1];
          wmode_q[j] <= wmode_q[j+1];
          wid_q[j]   <= wid_q[j+1];
        end
      end
    end else if (push_en) begin
      wpat_q[cnt_q[AddrW-1:0]]  <= pat_q;
      wmode_q[cnt_q[AddrW-1:0]] <= req_mode;
      wid_q[cnt_q[AddrW-1:0]]   <= tag_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.tag_out     = out_tag_q;
  assign rsp_o.result_bits = out_bits_q;
  assign rsp_o.woken_count = out_woken_q;
  assign rsp_o.last        = out_last_q;

  `EFG_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(MAX_WAITERS), "waiter count exceeds table size")
  `EFG_ASSERT_IMP(a_idx_bound, clk_i, rst_ni, state_q == S_SCAN, idx_q <= cnt_q, "scan index ran past the waiter count")
  `EFG_ASSERT_NXT(a_last_idle, clk_i, rst_ni, emit && e_last, state_q == S_IDLE, "final result did not end the item")
  `EFG_ASSERT_NXT(a_cancel_empty, clk_i, rst_ni, state_q == S_SCAN && op_q == OP_CANCEL && !in_range && out_free, cnt_q == '0, "cancel left waiters queued")

endmodule

`default_nettype wire

/* sim/event_flag_group_with_waiters_tb.sv */
// ----------------------------------------------------------------------------
// Event flag group with waiters testbench
// A table of directed operations runs first. Random operations follow under
// several sticky and initial flag settings. Both channels idle at random.
// Every result item is checked against a predictor that keeps its own flag
// word and waiter table; typed directed rows replace its final result.
// ----------------------------------------------------------------------------
`default_nettype none

module event_flag_group_with_waiters_tb;
  import efg_pkg::*;

  localparam int Period        = 20;
  localparam int ResetCycles   = 9;
  localparam int MaxWaiters    = 8;
  localparam int RandPerPhase  = 29;
  localparam int NumPhases     = 5;
  localparam int SettleCycles  = 16;
  localparam int HoldAfter     = 80;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;
  localparam int MaxReported   = 10;

  localparam logic [ModeW-1:0] ModeAnd    = 8'h01;
  localparam logic [ModeW-1:0] ModeOr     = 8'h02;
  localparam logic [ModeW-1:0] ModeClrAll = 8'h10;
  localparam logic [ModeW-1:0] ModeClrPat = 8'h20;
  localparam logic [ModeW-1:0] ModeIgnore = 8'hCC;

  localparam logic [OpW-1:0] OpUnknown6 = 3'd6;
  localparam logic [OpW-1:0] OpUnknown7 = 3'd7;

  localparam logic [FlagW-1:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [FlagW-1:0] TopBit  = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [TagW-1:0]    tag;
    logic [FlagW-1:0]   bits;
    logic [WokenW-1:0]  woken;
    logic               last;
  } flag_rsp_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [FlagW-1:0] pattern;
    logic [ModeW-1:0] mode;
    logic [TagW-1:0]  tag;
    logic             typed;
    flag_rsp_t        want;
  } dir_row_t;

  localparam int NumDir = 26;

  // Rows with typed set give the final result directly; the rest go through
  // the predictor. The waits near the end fill the table to its capacity.
  localparam dir_row_t DirRows [NumDir] = '{
    '{OP_CLEAR,   AllOnes,      8'h00,              3'd0, 1'b1,
      '{ST_OK,        3'd0, 64'h0, 4'd0, 1'b1}},
    '{OP_WAIT,    64'h0,        ModeAnd,            3'd3, 1'b1,
      '{ST_INVALID,   3'd3, 64'h0, 4'd0, 1'b1}},
    '{OP_TRYWAIT, AllOnes,      WaitType,           3'd5, 1'b1,
      '{ST_INVALID,   3'd5, 64'h0, 4'd0, 1'b1}},
    '{OP_WAIT,    64'h1,        8'h00,              3'd1, 1'b1,
      '{ST_INVALID,   3'd1, 64'h0, 4'd0, 1'b1}},
    '{OP_WAIT,    64'h1,        ModeAnd | ClearBoth, 3'd2, 1'b1,
      '{ST_INVALID,   3'd2, 64'h0, 4'd0, 1'b1}},
    '{OpUnknown6, AllOnes,      8'hFF,              3'd7, 1'b1,
      '{ST_INVALID,   3'd7, 64'h0, 4'd0, 1'b1}},
    '{OP_TIMEOUT, 64'h0,        8'h00,              3'd4, 1'b1,
      '{ST_INVALID,   3'd4, 64'h0, 4'd0, 1'b1}},
    '{OP_TRYWAIT, 64'h1,        ModeAnd,            3'd6, 1'b1,
      '{ST_BUSY,      3'd6, 64'h0, 4'd0, 1'b1}},
    '{OP_SET,     64'h0,        8'h00,              3'd0, 1'b1,
      '{ST_OK,        3'd0, 64'h0, 4'd0, 1'b1}},
    '{OP_WAIT,    64'hF,        ModeAnd,            3'd0, 1'b0, '0},
    '{OP_WAIT,    TopBit,       ModeOr | ModeClrAll, 3'd1, 1'b0, '0},
    '{OP_WAIT,    64'h3,        ModeAnd | ModeClrPat, 3'd2, 1'b0, '0},
    '{OP_WAIT,    64'h100,      ModeAnd | ModeIgnore, 3'd2, 1'b0, '0},
    '{OP_TIMEOUT, 64'h0,        8'h00,              3'd2, 1'b1,
      '{ST_TIMED_OUT, 3'd2, 64'h0, 4'd0, 1'b1}},
    '{OP_SET,     64'h3,        8'h00,              3'd0, 1'b0, '0},
    '{OP_TRYWAIT, 64'h1,        ModeOr | ModeClrPat, 3'd5, 1'b0, '0},
    '{OP_SET,     TopBit | 64'hD, 8'h00,            3'd0, 1'b0, '0},
    '{OP_WAIT,    AllOnes,      ModeAnd,            3'd0, 1'b0, '0},
    '{OP_WAIT,    AllOnes,      ModeAnd,            3'd1, 1'b0, '0},
    '{OP_WAIT,    AllOnes,      ModeAnd,            3'd2, 1'b0, '0},
    '{OP_WAIT,    AllOnes,      ModeAnd,            3'd3, 1'b0, '0},
    '{OP_WAIT,    AllOnes,      ModeAnd,            3'd4, 1'b0, '0},
    '{OP_WAIT,    AllOnes,      ModeAnd,            3'd5, 1'b0, '0},
    '{OP_WAIT,    AllOnes,      ModeAnd,            3'd6, 1'b0, '0},
    '{OP_WAIT,    AllOnes,      ModeOr,             3'd7, 1'b1,
      '{ST_FULL,      3'd7, 64'h0, 4'd0, 1'b1}},
    '{OP_CANCEL,  64'hA5A5_5A5A_C3C3_3C3C, 8'h00,   3'd0, 1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [FlagW-1:0]    cfg_data;

  efg_req_if req_if ();
  efg_rsp_if rsp_if ();

  event_flag_group_with_waiters #(
    .MAX_WAITERS(MaxWaiters)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predicted state of the block.
  logic [FlagW-1:0] flags_now;
  logic [FlagW-1:0] sticky_now;
  logic [FlagW-1:0] queued_pat  [MaxWaiters];
  wmode_t           queued_mode [MaxWaiters];
  logic [TagW-1:0]  queued_tag  [MaxWaiters];
  int               queued_count;

  flag_rsp_t pending_results [$];
  flag_rsp_t mon_got;
  flag_rsp_t mon_want;
  int        bad_results;
  int        results_seen;
  int        quiet_cycles;
  bit        hold_done;

  initial clk_i = 1'b0;
  always #(Period / 2) clk_i = ~clk_i;

  function automatic void push_result(logic [StatusW-1:0] status, logic [TagW-1:0] tag,
                                      logic [FlagW-1:0] bits, logic [WokenW-1:0] woken,
                                      logic last);
    flag_rsp_t r;
    r.status = status;
    r.tag    = tag;
    r.bits   = bits;
    r.woken  = woken;
    r.last   = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic bit waiter_met(logic [FlagW-1:0] pat, wmode_t wm);
    if (wm.or_mode) begin
      return (flags_now & pat) != '0;
    end
    return (flags_now & pat) == pat;
  endfunction

  // Returns the flag word seen by the waiter and applies its clear.
  function automatic logic [FlagW-1:0] consume_flags(logic [FlagW-1:0] pat, wmode_t wm);
    logic [FlagW-1:0] seen;
    seen = flags_now;
    if (wm.clr_all) begin
      flags_now = '0;
    end else if (wm.clr_pat) begin
      flags_now = flags_now & ~pat;
    end
    flags_now = flags_now | sticky_now;
    return seen;
  endfunction

  function automatic void drop_waiter(int idx);
    for (int j = idx; j + 1 < queued_count; j++) begin
      queued_pat[j]  = queued_pat[j + 1];
      queued_mode[j] = queued_mode[j + 1];
      queued_tag[j]  = queued_tag[j + 1];
    end
    queued_count--;
  endfunction

  function automatic void predict_flag_op(logic [OpW-1:0] op, logic [FlagW-1:0] pat,
                                          logic [ModeW-1:0] mode, logic [TagW-1:0] tag);
    int               i;
    int               n;
    bit               found;
    logic [FlagW-1:0] seen;
    wmode_t           wm;
    case (op)
      OP_SET: begin
        flags_now = flags_now | pat;
        i = 0;
        while (i < queued_count) begin
          if (waiter_met(queued_pat[i], queued_mode[i])) begin
            seen = consume_flags(queued_pat[i], queued_mode[i]);
            push_result(ST_OK, queued_tag[i], seen, '0, 1'b0);
            drop_waiter(i);
          end else begin
            i++;
          end
        end
        push_result(ST_OK, '0, flags_now, '0, 1'b1);
      end
      OP_CLEAR: begin
        flags_now = flags_now & pat;
        push_result(ST_OK, '0, flags_now, '0, 1'b1);
      end
      OP_WAIT, OP_TRYWAIT: begin
        wm.or_mode = (mode & ModeOr) != '0;
        wm.clr_all = (mode & ModeClrAll) != '0;
        wm.clr_pat = (mode & ModeClrPat) != '0;
        if (pat == '0 || (mode & WaitType) == '0 || (mode & WaitType) == WaitType ||
            (mode & ClearBoth) == ClearBoth) begin
          push_result(ST_INVALID, tag, '0, '0, 1'b1);
        end else if (waiter_met(pat, wm)) begin
          seen = consume_flags(pat, wm);
          push_result(ST_OK, tag, seen, '0, 1'b1);
        end else if (op == OP_TRYWAIT) begin
          push_result(ST_BUSY, tag, '0, '0, 1'b1);
        end else if (queued_count >= MaxWaiters) begin
          push_result(ST_FULL, tag, '0, '0, 1'b1);
        end else begin
          // The waiter is queued and produces no result item now.
          queued_pat[queued_count]  = pat;
          queued_mode[queued_count] = wm;
          queued_tag[queued_count]  = tag;
          queued_count++;
        end
      end
      OP_CANCEL: begin
        n = queued_count;
        for (i = 0; i < n; i++) begin
          push_result(ST_CANCELLED, queued_tag[i], pat, '0, 1'b0);
        end
        queued_count = 0;
        push_result(ST_OK, '0, pat, WokenW'(n), 1'b1);
      end
      OP_TIMEOUT: begin
        found = 1'b0;
        for (i = 0; i < queued_count && !found; i++) begin
          if (queued_tag[i] == tag) begin
            drop_waiter(i);
            found = 1'b1;
          end
        end
        push_result(found ? ST_TIMED_OUT : ST_INVALID, tag, '0, '0, 1'b1);
      end
      default: begin
        push_result(ST_INVALID, tag, '0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      return 0;
    end else if (sel < 90) begin
      return int'($urandom_range(1, 3));
    end
    return int'($urandom_range(8, 40));
  endfunction

  function automatic logic [OpW-1:0] pick_op();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return OP_SET;
    if (sel < 33) return OP_CLEAR;
    if (sel < 63) return OP_WAIT;
    if (sel < 75) return OP_TRYWAIT;
    if (sel < 80) return OP_CANCEL;
    if (sel < 94) return OP_TIMEOUT;
    if (sel < 97) return OpUnknown6;
    return OpUnknown7;
  endfunction

  // Most patterns sit in the low or the top byte so that sets and waits
  // overlap often enough to wake waiters.
  function automatic logic [FlagW-1:0] pick_pattern();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0:       return '0;
      1:       return AllOnes;
      2, 3:    return {$urandom, $urandom};
      4, 5:    return 64'd1 << $urandom_range(0, 63);
      default: return FlagW'($urandom_range(1, 255)) << (56 * $urandom_range(0, 1));
    endcase
  endfunction

  function automatic logic [ModeW-1:0] pick_mode();
    logic [ModeW-1:0] m;
    if ($urandom_range(0, 9) == 0) begin
      return ModeW'($urandom_range(0, 255));
    end
    m = ($urandom_range(0, 1) != 0) ? ModeOr : ModeAnd;
    case ($urandom_range(0, 2))
      1:       m = m | ModeClrAll;
      2:       m = m | ModeClrPat;
      default: m = m;
    endcase
    return m | (ModeW'($urandom_range(0, 255)) & ModeIgnore);
  endfunction

  function automatic void log_mismatch(string what, flag_rsp_t want, flag_rsp_t got);
    bad_results++;
    if (bad_results <= MaxReported) begin
      $display("%0t %s: expected status %0d tag %0d bits %h woken %0d last %0d,",
               $time, what, want.status, want.tag, want.bits, want.woken, want.last);
      $display("    got status %0d tag %0d bits %h woken %0d last %0d",
               got.status, got.tag, got.bits, got.woken, got.last);
    end
  endfunction

  // Offers one item after a random gap and predicts its results once taken.
  // A typed expectation replaces the final predicted result of the item.
  task automatic send_item(input logic [OpW-1:0] op, input logic [FlagW-1:0] pat,
                           input logic [ModeW-1:0] mode, input logic [TagW-1:0] tag,
                           input logic typed, input flag_rsp_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.pattern    <= pat;
    req_if.mode       <= mode;
    req_if.waiter_tag <= tag;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    predict_flag_op(op, pat, mode, tag);
    if (typed && pending_results.size() > 0) begin
      pending_results[pending_results.size() - 1] = want;
    end
  endtask

  // A queued wait leaves no result behind, so the block may still be busy
  // with it when the queue runs empty; the settle cycles cover that.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [FlagW-1:0] sticky_v,
                              input logic [FlagW-1:0] initial_v);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_STICKY;
    cfg_data <= sticky_v;
    @(posedge clk_i);
    sticky_now = sticky_v;
    cfg_idx  <= CFG_INITIAL;
    cfg_data <= initial_v;
    @(posedge clk_i);
    flags_now = initial_v;
    cfg_we <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      results_seen++;
      mon_got.status = rsp_if.status;
      mon_got.tag    = rsp_if.tag_out;
      mon_got.bits   = rsp_if.result_bits;
      mon_got.woken  = rsp_if.woken_count;
      mon_got.last   = rsp_if.last;
      if (pending_results.size() == 0) begin
        log_mismatch("unexpected result", '0, mon_got);
      end else begin
        mon_want = pending_results.pop_front();
        if (mon_got !== mon_want) begin
          log_mismatch("result mismatch", mon_want, mon_got);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps
  // offering items, so that the block backs up into its input.
  initial begin
    int run;
    int lo;
    rsp_if.ready = 1'b0;
    hold_done    = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 7) == 0) ? 60 : int'($urandom_range(1, 12));
      rsp_if.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      if (!hold_done && results_seen >= HoldAfter) begin
        hold_done = 1'b1;
        lo = HoldCycles;
      end else begin
        lo = pick_gap();
      end
      if (lo > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (lo) @(posedge clk_i);
      end
    end
  end

  // Watchdog on cycles in which nothing moves on any port.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [OpW-1:0]   op;
    logic [FlagW-1:0] pat;
    logic [TagW-1:0]  tag;
    logic [FlagW-1:0] sticky_v;
    logic [FlagW-1:0] initial_v;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.opcode     = '0;
    req_if.pattern    = '0;
    req_if.mode       = '0;
    req_if.waiter_tag = '0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_STICKY;
    cfg_data          = '0;
    flags_now         = '0;
    sticky_now        = '0;
    queued_count      = 0;
    bad_results       = 0;
    results_seen      = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NumDir; r++) begin
      send_item(DirRows[r].op, DirRows[r].pattern, DirRows[r].mode, DirRows[r].tag,
                DirRows[r].typed, DirRows[r].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          sticky_v  = '0;
          initial_v = AllOnes;
        end
        1: begin
          sticky_v  = AllOnes;
          initial_v = '0;
        end
        2: begin
          sticky_v  = {$urandom, $urandom} & {$urandom, $urandom};
          initial_v = {$urandom, $urandom};
        end
        3: begin
          sticky_v  = 64'd1 << $urandom_range(0, 63);
          initial_v = pick_pattern();
        end
        default: begin
          sticky_v  = '0;
          initial_v = '0;
        end
      endcase
      drain_results();
      write_config(sticky_v, initial_v);
      for (int k = 0; k < RandPerPhase; k++) begin
        op  = pick_op();
        pat = pick_pattern();
        if (op == OP_CLEAR && $urandom_range(0, 1) != 0) begin
          pat = ~pat;
        end
        tag = TagW'($urandom_range(0, 7));
        // Timeouts mostly name a waiter that is actually queued.
        if (op == OP_TIMEOUT && queued_count > 0 && $urandom_range(0, 3) != 0) begin
          tag = queued_tag[$urandom_range(0, queued_count - 1)];
        end
        send_item(op, pat, pick_mode(), tag, 1'b0, '0);
      end
    end

    drain_results();
    if (bad_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/efg_pkg.sv
rtl/core/efg_req_if.sv
rtl/core/efg_rsp_if.sv
rtl/core/event_flag_group_with_waiters.sv
sim/event_flag_group_with_waiters_tb.sv
